@@ sv/sktl_pkg.sv @@
package sktl_pkg;

    localparam int KEY_W            = 32;
    localparam int PLO_W            = 64;
    localparam int PHI_W            = 56;
    localparam int STATUS_W         = 3;
    localparam int DEFAULT_CAPACITY = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cell_flags_t;

endpackage

@@ sv/sktl_cell.sv @@
module sktl_cell #(
    parameter int CAPACITY = sktl_pkg::DEFAULT_CAPACITY,
    parameter int INDEX    = 0
) (
    input  logic                                clk,
    input  logic [$clog2(CAPACITY+1)-1:0]       count,
    input  logic                                cmp_en,
    input  logic                                upd_en,
    input  logic signed [sktl_pkg::KEY_W-1:0]   cmp_key,
    input  logic signed [sktl_pkg::KEY_W-1:0]   new_key,
    input  logic [sktl_pkg::PLO_W-1:0]          new_low,
    input  logic [sktl_pkg::PHI_W-1:0]          new_high,
    input  logic                                prev_lt,
    input  logic signed [sktl_pkg::KEY_W-1:0]   prev_key,
    input  logic [sktl_pkg::PLO_W-1:0]          prev_low,
    input  logic [sktl_pkg::PHI_W-1:0]          prev_high,
    output logic signed [sktl_pkg::KEY_W-1:0]   cur_key,
    output logic [sktl_pkg::PLO_W-1:0]          cur_low,
    output logic [sktl_pkg::PHI_W-1:0]          cur_high,
    output sktl_pkg::cell_flags_t               flags,
    output logic [sktl_pkg::PLO_W-1:0]          hit_low,
    output logic [sktl_pkg::PHI_W-1:0]          hit_high
);
    import sktl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] POS = CW'(INDEX);

    logic signed [KEY_W-1:0] key_reg;
    logic [PLO_W-1:0]        low_reg;
    logic [PHI_W-1:0]        high_reg;
    cell_flags_t             flags_reg;
    cell_flags_t             flags_next;
    logic                    occupied;

    assign occupied      = count > POS;
    assign flags_next.lt = occupied && (key_reg < cmp_key);
    assign flags_next.eq = occupied && (key_reg == cmp_key);

    always_ff @(posedge clk)
    begin
        if (cmp_en)
        begin
            flags_reg <= flags_next;
        end
        if (upd_en && !flags_reg.lt)
        begin
            if (prev_lt)
            begin
                key_reg  <= new_key;
                low_reg  <= new_low;
                high_reg <= new_high;
            end
            else
            begin
                key_reg  <= prev_key;
                low_reg  <= prev_low;
                high_reg <= prev_high;
            end
        end
    end

    assign cur_key  = key_reg;
    assign cur_low  = low_reg;
    assign cur_high = high_reg;
    assign flags    = flags_reg;
    assign hit_low  = flags_reg.eq ? low_reg : '0;
    assign hit_high = flags_reg.eq ? high_reg : '0;

endmodule

@@ sv/sorted_key_table_insert_lookup.sv @@
// Sorted key table: up to CAPACITY entries kept in ascending signed key order in a row of
// cells, one entry to a cell. An item is taken on the edge where in_valid and in_ready are
// both high; on that edge every cell compares its key with the item's key and registers the
// result. In S_EXEC, when the output register is free or being read, an insert whose key
// is not yet in a table that is not full shifts the cells from the insertion point onwards
// up by one place, the new entry lands in the gap, and the result goes into the output
// register. A new item is taken only once the last has left S_EXEC: the compare stage is
// followed by the shift stage of the cell row, and the shift stage waits while an earlier
// result has not been taken. The table is empty after reset and needs no clearing pass.
module sorted_key_table_insert_lookup #(
    parameter int CAPACITY = sktl_pkg::DEFAULT_CAPACITY
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 operation,
    input  logic signed [sktl_pkg::KEY_W-1:0]    key,
    input  logic [sktl_pkg::PLO_W-1:0]           payload_low,
    input  logic [sktl_pkg::PHI_W-1:0]           payload_high,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sktl_pkg::STATUS_W-1:0]        status,
    output logic [sktl_pkg::PLO_W-1:0]           found_low,
    output logic [sktl_pkg::PHI_W-1:0]           found_high
);
    import sktl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                  state_reg;
    logic [CW-1:0]           count_reg;
    logic                    op_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [PLO_W-1:0]        plo_reg;
    logic [PHI_W-1:0]        phi_reg;
    logic                    out_valid_reg;
    status_t                 status_reg;
    logic [PLO_W-1:0]        found_low_reg;
    logic [PHI_W-1:0]        found_high_reg;

    logic signed [KEY_W-1:0] cell_key  [CAPACITY];
    logic [PLO_W-1:0]        cell_low  [CAPACITY];
    logic [PHI_W-1:0]        cell_high [CAPACITY];
    cell_flags_t             cell_flags[CAPACITY];
    logic [PLO_W-1:0]        hit_low   [CAPACITY];
    logic [PHI_W-1:0]        hit_high  [CAPACITY];

    logic                    accept;
    logic                    exec_go;
    logic                    do_insert;
    logic                    any_eq;
    logic [PLO_W-1:0]        match_low;
    logic [PHI_W-1:0]        match_high;
    status_t                 status_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign exec_go   = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign do_insert = exec_go && (op_reg == OP_INSERT) && !any_eq
                       && (count_reg != FULL_COUNT);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                    p_lt;
            logic signed [KEY_W-1:0] p_key;
            logic [PLO_W-1:0]        p_low;
            logic [PHI_W-1:0]        p_high;

            if (gi == 0)
            begin : g_first
                assign p_lt   = 1'b1;
                assign p_key  = key_reg;
                assign p_low  = plo_reg;
                assign p_high = phi_reg;
            end
            else
            begin : g_rest
                assign p_lt   = cell_flags[gi-1].lt;
                assign p_key  = cell_key[gi-1];
                assign p_low  = cell_low[gi-1];
                assign p_high = cell_high[gi-1];
            end

            sktl_cell #(
                .CAPACITY (CAPACITY),
                .INDEX    (gi)
            ) u_cell (
                .clk       (clk),
                .count     (count_reg),
                .cmp_en    (accept),
                .upd_en    (do_insert),
                .cmp_key   (key),
                .new_key   (key_reg),
                .new_low   (plo_reg),
                .new_high  (phi_reg),
                .prev_lt   (p_lt),
                .prev_key  (p_key),
                .prev_low  (p_low),
                .prev_high (p_high),
                .cur_key   (cell_key[gi]),
                .cur_low   (cell_low[gi]),
                .cur_high  (cell_high[gi]),
                .flags     (cell_flags[gi]),
                .hit_low   (hit_low[gi]),
                .hit_high  (hit_high[gi])
            );
        end
    endgenerate

    always_comb
    begin
        any_eq     = 1'b0;
        match_low  = '0;
        match_high = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            any_eq     = any_eq | cell_flags[i].eq;
            match_low  = match_low | hit_low[i];
            match_high = match_high | hit_high[i];
        end
    end

    always_comb
    begin
        if (op_reg == OP_LOOKUP)
        begin
            status_next = any_eq ? ST_FOUND : ST_NOT_FOUND;
        end
        else if (any_eq)
        begin
            status_next = ST_DUPLICATE;
        end
        else if (count_reg == FULL_COUNT)
        begin
            status_next = ST_FULL;
        end
        else
        begin
            status_next = ST_INSERTED;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            key_reg <= key;
            plo_reg <= payload_low;
            phi_reg <= payload_high;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= ST_INSERTED;
            found_low_reg  <= '0;
            found_high_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_EXEC;
                    end
                    if (out_valid_reg && out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                S_EXEC:
                begin
                    if (exec_go)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b1;
                        status_reg    <= status_next;
                        if (op_reg == OP_LOOKUP)
                        begin
                            found_low_reg  <= match_low;
                            found_high_reg <= match_high;
                        end
                        else
                        begin
                            found_low_reg  <= '0;
                            found_high_reg <= '0;
                        end
                        if (do_insert)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign found_low  = found_low_reg;
    assign found_high = found_high_reg;

endmodule

@@ dv/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sktl_pkg::*;

    localparam int CAPACITY = DEFAULT_CAPACITY;
    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    typedef struct {
        op_t                     op;
        logic signed [KEY_W-1:0] key;
        logic [PLO_W-1:0]        plo;
        logic [PHI_W-1:0]        phi;
    } item_t;

    typedef struct {
        status_t          st;
        logic [PLO_W-1:0] lo;
        logic [PHI_W-1:0] hi;
    } result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    operation = 1'b0;
    logic signed [KEY_W-1:0] key = '0;
    logic [PLO_W-1:0]        payload_low = '0;
    logic [PHI_W-1:0]        payload_high = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [STATUS_W-1:0]     status;
    logic [PLO_W-1:0]        found_low;
    logic [PHI_W-1:0]        found_high;

    sorted_key_table_insert_lookup #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .key(key),
        .payload_low(payload_low),
        .payload_high(payload_high),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .found_low(found_low),
        .found_high(found_high)
    );

    // Predicted contents of the table.
    logic signed [KEY_W-1:0] tbl_key [CAPACITY];
    logic [PLO_W-1:0]        tbl_plo [CAPACITY];
    logic [PHI_W-1:0]        tbl_phi [CAPACITY];
    int                      tbl_count = 0;
    int                      status_tally [5] = '{default: 0};

    item_t   pending_items [$];
    result_t expected_results [$];
    item_t   item_on_bus;
    int      items_accepted = 0;
    int      mismatch_count = 0;
    int      send_idle_pct = 7;
    int      recv_idle_pct = 65;
    int      hold_serial = 0;
    int      hold_seen = 0;
    int      hold_left = 0;

    logic signed [KEY_W-1:0] resident_keys [$];

    function automatic result_t table_apply(item_t it);
        result_t r;
        int      pos;
        logic    hit;
        pos = 0;
        while (pos < tbl_count && tbl_key[pos] < it.key)
            pos++;
        hit = (pos < tbl_count) && (tbl_key[pos] == it.key);
        r.lo = '0;
        r.hi = '0;
        if (it.op == OP_LOOKUP) begin
            if (hit) begin
                r.st = ST_FOUND;
                r.lo = tbl_plo[pos];
                r.hi = tbl_phi[pos];
            end
            else
                r.st = ST_NOT_FOUND;
        end
        else if (hit)
            r.st = ST_DUPLICATE;
        else if (tbl_count >= CAPACITY)
            r.st = ST_FULL;
        else begin
            for (int i = tbl_count; i > pos; i--) begin
                tbl_key[i] = tbl_key[i-1];
                tbl_plo[i] = tbl_plo[i-1];
                tbl_phi[i] = tbl_phi[i-1];
            end
            tbl_key[pos] = it.key;
            tbl_plo[pos] = it.plo;
            tbl_phi[pos] = it.phi;
            tbl_count++;
            r.st = ST_INSERTED;
        end
        status_tally[int'(r.st)]++;
        return r;
    endfunction

    function automatic logic [PLO_W-1:0] rand_low();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [PHI_W-1:0] rand_high();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[PHI_W-1:0];
    endfunction

    function automatic logic is_resident(logic signed [KEY_W-1:0] k);
        foreach (resident_keys[i])
            if (resident_keys[i] == k)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic signed [KEY_W-1:0] fresh_key();
        logic signed [KEY_W-1:0] k;
        k = $urandom;
        while (is_resident(k))
            k = $urandom;
        return k;
    endfunction

    task automatic add_item(op_t op, logic signed [KEY_W-1:0] k,
                            logic [PLO_W-1:0] lo, logic [PHI_W-1:0] hi);
        item_t it;
        it.op = op;
        it.key = k;
        it.plo = lo;
        it.phi = hi;
        pending_items.push_back(it);
        if (op == OP_INSERT && !is_resident(k) && resident_keys.size() < CAPACITY)
            resident_keys.push_back(k);
    endtask

    task automatic add_random(int n);
        logic signed [KEY_W-1:0] k;
        int                      pick;
        op_t                     op;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            k = resident_keys[$urandom_range(resident_keys.size() - 1)];
            op = OP_LOOKUP;
            if (pick < 15)
                k = $urandom;
            else if (pick < 25)
                k = ($urandom_range(1) != 0) ? k + 1 : k - 1;
            else if (pick < 40)
                op = OP_INSERT;
            else if (pick < 50) begin
                op = OP_INSERT;
                k = $urandom;
            end
            add_item(op, k, rand_low(), rand_high());
        end
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    always #5 clk = ~clk;

    // Driver: offers the queued items one at a time.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                expected_results.push_back(table_apply(item_on_bus));
                items_accepted++;
            end
            if (!in_valid || in_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item_on_bus = pending_items.pop_front();
                    in_valid <= 1'b1;
                    operation <= item_on_bus.op;
                    key <= item_on_bus.key;
                    payload_low <= item_on_bus.plo;
                    payload_high <= item_on_bus.phi;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result item against the oldest prediction.
    always @(posedge clk) begin
        result_t exp_r;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, status %0d low %h high %h",
                             $realtime, status, found_low, found_high);
                    mismatch_count++;
                end
                else begin
                    exp_r = expected_results.pop_front();
                    if (status !== exp_r.st) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, exp_r.st, status);
                        mismatch_count++;
                    end
                    if (found_low !== exp_r.lo) begin
                        $display("%0t: found_low expected %h actual %h",
                                 $realtime, exp_r.lo, found_low);
                        mismatch_count++;
                    end
                    if (found_high !== exp_r.hi) begin
                        $display("%0t: found_high expected %h actual %h",
                                 $realtime, exp_r.hi, found_high);
                        mismatch_count++;
                    end
                end
            end
            if (hold_seen != hold_serial) begin
                hold_seen = hold_serial;
                hold_left = 150;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        #2_000_000;
        $display("sorted_key_table_insert_lookup: mismatch");
        $finish;
    end

    initial begin
        @(negedge clk);
        // Directed part: empty table, extreme keys, duplicates, then fill to capacity and beyond.
        add_item(OP_LOOKUP, 32'sd0, rand_low(), rand_high());
        add_item(OP_INSERT, 32'sd0, '1, '1);
        add_item(OP_INSERT, KEY_MIN, '0, '0);
        add_item(OP_INSERT, KEY_MAX, rand_low(), rand_high());
        add_item(OP_INSERT, -32'sd1, rand_low(), rand_high());
        add_item(OP_INSERT, 32'sd0, rand_low(), rand_high());
        add_item(OP_LOOKUP, -32'sd1, '1, '1);
        add_item(OP_LOOKUP, 32'sd5, '0, '0);
        while (resident_keys.size() < CAPACITY)
            add_item(OP_INSERT, fresh_key(), rand_low(), rand_high());
        add_item(OP_INSERT, fresh_key(), rand_low(), rand_high());
        add_item(OP_INSERT, KEY_MAX, rand_low(), rand_high());
        add_item(OP_LOOKUP, KEY_MIN, rand_low(), rand_high());
        add_item(OP_LOOKUP, KEY_MAX, rand_low(), rand_high());
        add_item(OP_LOOKUP, 32'sd0, rand_low(), rand_high());

        add_random(260);
        hold_serial++;
        drain();

        send_idle_pct = 65;
        recv_idle_pct = 7;
        add_random(280);
        hold_serial++;
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(290);
        hold_serial++;
        drain();

        repeat (20) @(negedge clk);
        $display("Ran %0d items through a table of %0d entries, stalls on both sides.",
                 items_accepted, CAPACITY);
        $display("Inserted %0d, duplicate %0d, full %0d, found %0d, not found %0d.",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3],
                 status_tally[4]);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("sorted_key_table_insert_lookup: match");
        else
            $display("sorted_key_table_insert_lookup: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
sv/sktl_pkg.sv
sv/sktl_cell.sv
sv/sorted_key_table_insert_lookup.sv
dv/testbench.sv
